### rtl/oaht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types, codes and constants of the open-address hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

    localparam int TABLE_SIZE = 2048;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    localparam int ADDR_W     = SLOT_W + 1;
    localparam int KEY_W      = 48;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 3;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] RES_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] RES_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] RES_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] RES_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] RES_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] RES_DELETED   = 3'd5;
    localparam logic [STATUS_W-1:0] RES_BAD_KEY   = 3'd6;

    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_USED  = 2'd1;
    localparam logic [1:0] SLOT_TOMB  = 2'd2;

    localparam logic [7:0] DIGIT_LO  = 8'd48;
    localparam logic [7:0] DIGIT_HI  = 8'd57;
    localparam logic [7:0] LETTER_LO = 8'd65;
    localparam logic [7:0] LETTER_HI = 8'd90;

    // reciprocals for the hash: floor(2^40 / 10^6), floor(2^27 / 100)
    localparam logic [20:0] RECIP_MOD = 21'd1099511;
    localparam logic [19:0] MOD_VAL   = 20'd1000000;
    localparam logic [20:0] RECIP_DIV = 21'd1342177;
    localparam logic [6:0]  DIV_VAL   = 7'd100;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [1:0]        state;
        logic [KEY_W-1:0]  key;
    } t_mem_wr;

    // ceil(2^12 / (3 * (i + 1)))
    function automatic logic [10:0] char_recip(input logic [2:0] idx);
        logic [10:0] m;
        case (idx)
            3'd0:    m = 11'd1366;
            3'd1:    m = 11'd683;
            3'd2:    m = 11'd456;
            3'd3:    m = 11'd342;
            3'd4:    m = 11'd274;
            3'd5:    m = 11'd228;
            default: m = 11'd0;
        endcase
        return m;
    endfunction

    function automatic logic key_ok(input logic [KEY_W-1:0] key);
        logic       ok;
        logic [7:0] c;
        ok = 1'b1;
        for (int i = 0; i < 6; i++) begin
            c = key[8*(5-i) +: 8];
            if (i >= 1 && i <= 3) begin
                if (c < DIGIT_LO || c > DIGIT_HI) ok = 1'b0;
            end else begin
                if (c < LETTER_LO || c > LETTER_HI) ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

### rtl/open_address_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_address_hash_table
// Hash table of 2048 slots for six-character keys: insert, find and delete
// with linear probing in steps of two, stopping at the table end.
// ----------------------------------------------------------------------------
// s_axis carries one operation per word: tuser is the kind (insert, find,
// delete), tdata the key. m_axis returns one word per operation: status and
// slot. After reset the slot memory is swept empty, one slot a cycle, so
// s_axis_tready stays low until the sweep is done. One operation is worked
// at a time. A malformed key or unused kind skips the hash and the probes and
// goes straight to the result. Otherwise the home slot is worked out on the
// shared multiplier (two products per key character, the square, then
// reciprocal steps for mod and divide), and each probed slot passes through a
// memory read, then a compare. The result sits in an output register; a
// new word is taken while it waits, and a stalled m_axis holds the block
// only when a second result is ready behind it.
// ----------------------------------------------------------------------------
module open_address_hash_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // key
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // status, slot, zero pad
);

    localparam int SLOT_W = oaht_pkg::SLOT_W;
    localparam int ADDR_W = oaht_pkg::ADDR_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HASH = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                   r_state, n_state;
    logic [oaht_pkg::KIND_W-1:0]  r_kind, n_kind;
    logic [oaht_pkg::KEY_W-1:0]   r_key, n_key;
    logic [ADDR_W-1:0]            r_addr, n_addr;
    logic                         r_free_vld, n_free_vld;
    logic [SLOT_W-1:0]            r_free_slot, n_free_slot;
    logic [oaht_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic [SLOT_W-1:0]            r_res_slot, n_res_slot;
    logic                         r_out_vld, n_out_vld;
    logic [oaht_pkg::STATUS_W+SLOT_W-1:0] r_out_data, n_out_data;

    logic                       in_acc;
    logic                       hash_start;
    logic                       hash_done;
    logic [SLOT_W-1:0]          hash_home;
    logic                       rd_en;
    logic [1:0]                 rd_state;
    logic [oaht_pkg::KEY_W-1:0] rd_key;
    logic                       clr_busy;
    oaht_pkg::t_mem_wr          wr;

    logic              hit;
    logic              slot_empty;
    logic [ADDR_W-1:0] next_addr;
    logic              at_end;
    logic              free_now;
    logic [SLOT_W-1:0] free_pick;

    oaht_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (r_key),
        .o_done  (hash_done),
        .o_home  (hash_home)
    );

    oaht_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_addr[SLOT_W-1:0]),
        .i_wr       (wr),
        .o_rd_state (rd_state),
        .o_rd_key   (rd_key),
        .o_busy     (clr_busy)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !clr_busy;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign rd_en         = (r_state == S_RD);

    assign hit        = (rd_state == oaht_pkg::SLOT_USED) && (rd_key == r_key);
    assign slot_empty = (rd_state == oaht_pkg::SLOT_EMPTY);
    assign next_addr  = r_addr + ADDR_W'(2);
    assign at_end     = next_addr[ADDR_W-1];
    assign free_now   = (rd_state != oaht_pkg::SLOT_USED);
    assign free_pick  = r_free_vld ? r_free_slot : r_addr[SLOT_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_key        = r_key;
        n_addr       = r_addr;
        n_free_vld   = r_free_vld;
        n_free_slot  = r_free_slot;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_out_vld    = r_out_vld;
        n_out_data   = r_out_data;
        hash_start   = 1'b0;
        wr.en        = 1'b0;
        wr.addr      = r_addr[SLOT_W-1:0];
        wr.state     = oaht_pkg::SLOT_USED;
        wr.key       = r_key;

        if (r_out_vld && m_axis_tready) n_out_vld = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_kind     = s_axis_tuser;
                    n_key      = s_axis_tdata;
                    n_free_vld = 1'b0;
                    if (s_axis_tuser == oaht_pkg::KIND_UNUSED
                        || !oaht_pkg::key_ok(s_axis_tdata)) begin
                        n_res_status = oaht_pkg::RES_BAD_KEY;
                        n_res_slot   = '0;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                hash_start = 1'b1;
                if (hash_done) begin
                    hash_start = 1'b0;
                    n_addr     = {1'b0, hash_home};
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_kind == oaht_pkg::KIND_INSERT) begin
                    if (hit) begin
                        n_res_status = oaht_pkg::RES_DUPLICATE;
                        n_res_slot   = '0;
                        n_state      = S_DONE;
                    end else if (slot_empty || (at_end && (free_now || r_free_vld))) begin
                        wr.en        = 1'b1;
                        wr.addr      = free_pick;
                        wr.state     = oaht_pkg::SLOT_USED;
                        n_res_status = oaht_pkg::RES_INSERTED;
                        n_res_slot   = free_pick;
                        n_state      = S_DONE;
                    end else if (at_end) begin
                        n_res_status = oaht_pkg::RES_FULL;
                        n_res_slot   = '0;
                        n_state      = S_DONE;
                    end else begin
                        if (free_now && !r_free_vld) begin
                            n_free_vld  = 1'b1;
                            n_free_slot = r_addr[SLOT_W-1:0];
                        end
                        n_addr  = next_addr;
                        n_state = S_RD;
                    end
                end else begin
                    if (hit) begin
                        n_res_slot = r_addr[SLOT_W-1:0];
                        if (r_kind == oaht_pkg::KIND_DELETE) begin
                            wr.en        = 1'b1;
                            wr.state     = oaht_pkg::SLOT_TOMB;
                            n_res_status = oaht_pkg::RES_DELETED;
                        end else begin
                            n_res_status = oaht_pkg::RES_FOUND;
                        end
                        n_state = S_DONE;
                    end else if (slot_empty || at_end) begin
                        n_res_status = oaht_pkg::RES_NOT_FOUND;
                        n_res_slot   = '0;
                        n_state      = S_DONE;
                    end else begin
                        n_addr  = next_addr;
                        n_state = S_RD;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {r_res_slot, r_res_status};
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_key        <= n_key;
        r_addr       <= n_addr;
        r_free_vld   <= n_free_vld;
        r_free_slot  <= n_free_slot;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_out_data   <= n_out_data;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out_data};

endmodule

### rtl/oaht_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_hash
// Home slot unit: one shared multiplier stepped through the character sum,
// the square and the reciprocal-based mod and divide.
// ----------------------------------------------------------------------------
module oaht_hash (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [oaht_pkg::KEY_W-1:0] i_key,
    output logic                      o_done,
    output logic [oaht_pkg::SLOT_W-1:0] o_home
);

    localparam logic [3:0] H_IDLE = 4'd0;
    localparam logic [3:0] H_MQ   = 4'd1;
    localparam logic [3:0] H_MS   = 4'd2;
    localparam logic [3:0] H_SQ   = 4'd3;
    localparam logic [3:0] H_D1   = 4'd4;
    localparam logic [3:0] H_D2   = 4'd5;
    localparam logic [3:0] H_D3   = 4'd6;
    localparam logic [3:0] H_D4   = 4'd7;
    localparam logic [3:0] H_D5   = 4'd8;
    localparam logic [3:0] H_D6   = 4'd9;

    logic [3:0]  r_state;
    logic [2:0]  r_idx;
    logic [5:0]  r_q;
    logic [13:0] r_s;
    logic [28:0] r_t;
    logic [9:0]  r_q1;
    logic [20:0] r_r;
    logic [13:0] r_q2;
    logic        r_bump;
    logic        r_done;
    logic [oaht_pkg::SLOT_W-1:0] r_home;

    logic [6:0]  c;
    logic [29:0] mul_a;
    logic [20:0] mul_b;
    logic [50:0] prod;
    logic [28:0] d2_diff;
    logic [19:0] d5_diff;
    logic [13:0] home_sum;

    always_comb begin
        case (r_idx)
            3'd0:    c = i_key[46:40];
            3'd1:    c = i_key[38:32];
            3'd2:    c = i_key[30:24];
            3'd3:    c = i_key[22:16];
            3'd4:    c = i_key[14:8];
            3'd5:    c = i_key[6:0];
            default: c = 7'd0;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            H_MQ: begin
                mul_a = 30'(c);
                mul_b = 21'(oaht_pkg::char_recip(r_idx));
            end
            H_MS: begin
                mul_a = 30'(c);
                mul_b = 21'(r_q);
            end
            H_SQ: begin
                mul_a = 30'(r_s);
                mul_b = 21'(r_s);
            end
            H_D1: begin
                mul_a = 30'(r_t);
                mul_b = oaht_pkg::RECIP_MOD;
            end
            H_D2: begin
                mul_a = 30'(r_q1);
                mul_b = 21'(oaht_pkg::MOD_VAL);
            end
            H_D4: begin
                mul_a = 30'(r_r);
                mul_b = oaht_pkg::RECIP_DIV;
            end
            H_D5: begin
                mul_a = 30'(r_q2);
                mul_b = 21'(oaht_pkg::DIV_VAL);
            end
            default: begin
                mul_a = 30'd0;
                mul_b = 21'd0;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign d2_diff  = r_t - prod[28:0];
    assign d5_diff  = r_r[19:0] - prod[19:0];
    assign home_sum = r_q2 + 14'(r_bump);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_idx   <= 3'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_idx   <= 3'd0;
                        r_s     <= 14'd0;
                        r_state <= H_MQ;
                    end
                end
                H_MQ: begin
                    r_q     <= prod[17:12];
                    r_state <= H_MS;
                end
                H_MS: begin
                    r_s <= r_s + prod[13:0];
                    if (r_idx == 3'd5) begin
                        r_state <= H_SQ;
                    end else begin
                        r_idx   <= r_idx + 3'd1;
                        r_state <= H_MQ;
                    end
                end
                H_SQ: begin
                    r_t     <= {prod[27:0], 1'b0};
                    r_state <= H_D1;
                end
                H_D1: begin
                    r_q1    <= prod[49:40];
                    r_state <= H_D2;
                end
                H_D2: begin
                    r_r     <= d2_diff[20:0];
                    r_state <= H_D3;
                end
                H_D3: begin
                    if (r_r >= 21'(oaht_pkg::MOD_VAL)) begin
                        r_r <= r_r - 21'(oaht_pkg::MOD_VAL);
                    end
                    r_state <= H_D4;
                end
                H_D4: begin
                    r_q2    <= prod[40:27];
                    r_state <= H_D5;
                end
                H_D5: begin
                    r_bump  <= (d5_diff >= 20'(oaht_pkg::DIV_VAL));
                    r_state <= H_D6;
                end
                H_D6: begin
                    r_home  <= home_sum[oaht_pkg::SLOT_W-1:0];
                    r_done  <= 1'b1;
                    r_state <= H_IDLE;
                end
                default: begin
                    r_state <= H_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_home = r_home;

endmodule

### rtl/oaht_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_store
// Slot memory holding slot state and key, one read and one write port,
// registered read data, with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module oaht_store (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [oaht_pkg::SLOT_W-1:0] i_rd_addr,
    input  oaht_pkg::t_mem_wr           i_wr,
    output logic [1:0]                  o_rd_state,
    output logic [oaht_pkg::KEY_W-1:0]  o_rd_key,
    output logic                        o_busy
);

    localparam int WORD_W = oaht_pkg::KEY_W + 2;

    logic [WORD_W-1:0] mem [oaht_pkg::TABLE_SIZE];
    logic [WORD_W-1:0] r_rd_word;
    logic              r_clr_busy;
    logic [oaht_pkg::SLOT_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + {{(oaht_pkg::SLOT_W-1){1'b0}}, 1'b1};
            if (&r_clr_addr) r_clr_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= {oaht_pkg::SLOT_EMPTY, {oaht_pkg::KEY_W{1'b0}}};
        end else if (i_wr.en) begin
            mem[i_wr.addr] <= {i_wr.state, i_wr.key};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) r_rd_word <= mem[i_rd_addr];
    end

    assign o_rd_state = r_rd_word[WORD_W-1 -: 2];
    assign o_rd_key   = r_rd_word[oaht_pkg::KEY_W-1:0];
    assign o_busy     = r_clr_busy;

endmodule
